// ===== rtl/pqw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqw_pkg
// Shared constants, codes, types and the term table of the post-order
// quartet weight block.
// ----------------------------------------------------------------------------
package pqw_pkg;

   // Default configuration of the block
   localparam int DEF_STACK_DEPTH = 32;
   localparam int DEF_LABEL_COUNT = 32;
   localparam int DEF_COUNT_WIDTH = 8;

   // Fixed field widths
   localparam int MAP_WIDTH       = 64;
   localparam int TOTAL_WIDTH     = 8;
   localparam int LABEL_WIDTH     = 5;
   localparam int OPCODE_WIDTH    = 2;
   localparam int WEIGHT_WIDTH    = 64;
   localparam int ERROR_WIDTH     = 2;
   localparam int FILL_WIDTH      = 6;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   // Queue between front and back, and the term sequencer
   localparam int QUEUE_DEPTH    = 4;
   localparam int TERM_COUNT     = 6;
   localparam int TERM_IDX_WIDTH = 3;
   localparam int TERM_BIAS      = 3;

   // Token kinds
   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_LEAF  = 2'd0,
      OP_MERGE = 2'd1,
      OP_END   = 2'd2
   } opcode_type;

   // Stack status reported with every item
   typedef enum logic [ERROR_WIDTH-1:0] {
      ERR_NONE      = 2'd0,
      ERR_UNDERFLOW = 2'd1,
      ERR_OVERFLOW  = 2'd2
   } error_type;

   // Side codes of the label map
   localparam logic [1:0] SIDE_A    = 2'd0;
   localparam logic [1:0] SIDE_B    = 2'd1;
   localparam logic [1:0] SIDE_C    = 2'd2;
   localparam logic [1:0] SIDE_NONE = 2'd3;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIDE_MAP = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOTAL_A  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOTAL_B  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOTAL_C  = 3'd3;

   // Weight limits and the value of a term with a negative count
   localparam logic signed [WEIGHT_WIDTH-1:0] WEIGHT_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [WEIGHT_WIDTH-1:0] WEIGHT_MIN   = 64'sh8000_0000_0000_0000;
   localparam logic signed [WEIGHT_WIDTH-1:0] TERM_NEG_ONE = -64'sd1;

   // Control part of one queued item
   typedef struct packed {
      logic                  is_merge;
      error_type             err;
      logic [FILL_WIDTH-1:0] fill;
   } tag_type;

   // Sides of p, q and r for each of the six terms, packed {p, q, r}
   function automatic logic [5:0] term_sides(input logic [TERM_IDX_WIDTH-1:0] idx);
      logic [5:0] sides;
      unique case (idx)
         3'd0:    sides = {SIDE_A, SIDE_B, SIDE_C};
         3'd1:    sides = {SIDE_A, SIDE_C, SIDE_B};
         3'd2:    sides = {SIDE_B, SIDE_A, SIDE_C};
         3'd3:    sides = {SIDE_B, SIDE_C, SIDE_A};
         3'd4:    sides = {SIDE_C, SIDE_A, SIDE_B};
         3'd5:    sides = {SIDE_C, SIDE_B, SIDE_A};
         default: sides = {SIDE_A, SIDE_A, SIDE_A};
      endcase
      return sides;
   endfunction

endpackage

// ===== rtl/pqw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqw_front
// Accepts tokens, runs the vector stack and hands one classified item per
// token to the queue: stack status plus, for a merge, both operands and sum.
// ----------------------------------------------------------------------------
module pqw_front #(
   parameter int STACK_DEPTH  = pqw_pkg::DEF_STACK_DEPTH,
   parameter int LABEL_COUNT  = pqw_pkg::DEF_LABEL_COUNT,
   parameter int COUNT_WIDTH  = pqw_pkg::DEF_COUNT_WIDTH,
   localparam int REC_WIDTH   = $bits(pqw_pkg::tag_type) + 9 * COUNT_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [pqw_pkg::OPCODE_WIDTH-1:0]     req_opcode,
   input  logic [pqw_pkg::LABEL_WIDTH-1:0]      req_leaf_label,
   input  logic [pqw_pkg::MAP_WIDTH-1:0]        side_map,
   input  logic                                 q_full,
   output logic                                 q_push,
   output logic [REC_WIDTH-1:0]                 q_data
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int TRIO_W = 3 * COUNT_WIDTH;
   localparam int FILL_W = pqw_pkg::FILL_WIDTH;
   localparam int SEL_W  = pqw_pkg::LABEL_WIDTH + 1;

   typedef enum logic [1:0] {
      F_TAKE  = 2'b01,
      F_MERGE = 2'b10
   } fstate_type;

   fstate_type          fstate_ff, fstate_in;
   logic [CNT_W-1:0]    count_ff, count_in, count_m1, count_m2;
   logic [TRIO_W-1:0]   top_ff, top_in;
   logic [TRIO_W-1:0]   rd_data_ff;
   logic [TRIO_W-1:0]   stack_mem [STACK_DEPTH];
   logic [TRIO_W-1:0]   leaf_vec, sum_vec;
   logic [TRIO_W-1:0]   rec_x, rec_y, rec_s;
   logic [COUNT_WIDTH:0] part_sum;
   logic                mem_we, rd_en, accept;
   logic [1:0]          side_code;
   pqw_pkg::opcode_type opcode;
   pqw_pkg::tag_type    tag;

   // Take a token only in the accept state with room in the queue
   assign req_stall = (fstate_ff != F_TAKE) || q_full;
   assign accept    = req_valid && !req_stall;
   assign opcode    = pqw_pkg::opcode_type'(req_opcode);
   assign count_m1  = count_ff - CNT_W'(1);
   assign count_m2  = count_ff - CNT_W'(2);

   // Look up the side of the label; labels past the map count as unmapped
   always_comb begin
      if (SEL_W'(req_leaf_label) < SEL_W'(LABEL_COUNT)) begin
         side_code = side_map[{req_leaf_label, 1'b0} +: 2];
      end else begin
         side_code = pqw_pkg::SIDE_NONE;
      end
   end

   // Build the one-hot leaf vector
   always_comb begin
      leaf_vec = '0;
      unique case (side_code)
         pqw_pkg::SIDE_A: leaf_vec[0]               = 1'b1;
         pqw_pkg::SIDE_B: leaf_vec[COUNT_WIDTH]     = 1'b1;
         pqw_pkg::SIDE_C: leaf_vec[2 * COUNT_WIDTH] = 1'b1;
         default:         leaf_vec                  = '0;
      endcase
   end

   // Add the top two vectors, each count saturating
   always_comb begin
      sum_vec  = '0;
      part_sum = '0;
      for (int k = 0; k < 3; k++) begin
         part_sum = {1'b0, top_ff[k * COUNT_WIDTH +: COUNT_WIDTH]}
                  + {1'b0, rd_data_ff[k * COUNT_WIDTH +: COUNT_WIDTH]};
         sum_vec[k * COUNT_WIDTH +: COUNT_WIDTH] =
            part_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : part_sum[COUNT_WIDTH-1:0];
      end
   end

   // Stack control and item classification
   always_comb begin
      fstate_in    = fstate_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      q_push       = 1'b0;
      tag.is_merge = 1'b0;
      tag.err      = pqw_pkg::ERR_NONE;
      rec_x        = top_ff;
      rec_y        = rd_data_ff;
      rec_s        = sum_vec;
      unique case (fstate_ff)
         F_TAKE: begin
            if (accept) begin
               q_push = 1'b1;
               unique case (opcode)
                  pqw_pkg::OP_LEAF: begin
                     if (count_ff == CNT_W'(STACK_DEPTH)) begin
                        tag.err = pqw_pkg::ERR_OVERFLOW;
                     end else begin
                        // spill the old top below the new one
                        mem_we   = (count_ff != '0);
                        top_in   = leaf_vec;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  pqw_pkg::OP_MERGE: begin
                     if (count_ff < CNT_W'(2)) begin
                        tag.err = pqw_pkg::ERR_UNDERFLOW;
                     end else begin
                        // fetch the second vector, finish next cycle
                        q_push    = 1'b0;
                        rd_en     = 1'b1;
                        fstate_in = F_MERGE;
                     end
                  end
                  pqw_pkg::OP_END: begin
                     count_in = '0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         F_MERGE: begin
            q_push       = 1'b1;
            tag.is_merge = 1'b1;
            top_in       = sum_vec;
            count_in     = count_m1;
            fstate_in    = F_TAKE;
         end
         default: begin
            fstate_in = F_TAKE;
         end
      endcase
      tag.fill = FILL_W'(count_in);
   end

   assign q_data = {tag, rec_x, rec_y, rec_s};

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fstate_ff <= F_TAKE;
         count_ff  <= '0;
      end else begin
         fstate_ff <= fstate_in;
         count_ff  <= count_in;
      end
   end

   // Top of stack register and the stack memory below it
   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (mem_we) begin
         stack_mem[count_m1[ADDR_W-1:0]] <= top_ff;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[count_m2[ADDR_W-1:0]];
      end
   end

endmodule

// ===== rtl/pqw_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqw_queue
// Short first-in first-out queue of items between the front and the back.
// ----------------------------------------------------------------------------
module pqw_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = pqw_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic             do_push, do_pop;

   assign full      = (used_ff == CNT_W'(DEPTH));
   assign empty     = (used_ff == '0);
   assign head_data = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   // Advance pointers with wrap, track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      used_in   = used_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         used_in = used_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         used_in = used_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/pqw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqw_back
// Takes items from the queue in order, runs the six F terms of a merge
// through a shared two-stage multiplier, keeps the saturating weight and
// drives the result register.
// ----------------------------------------------------------------------------
module pqw_back #(
   parameter int COUNT_WIDTH = pqw_pkg::DEF_COUNT_WIDTH,
   localparam int REC_WIDTH  = $bits(pqw_pkg::tag_type) + 9 * COUNT_WIDTH
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      q_empty,
   input  logic [REC_WIDTH-1:0]                      q_head,
   output logic                                      q_pop,
   input  logic [pqw_pkg::TOTAL_WIDTH-1:0]           total_side_a,
   input  logic [pqw_pkg::TOTAL_WIDTH-1:0]           total_side_b,
   input  logic [pqw_pkg::TOTAL_WIDTH-1:0]           total_side_c,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [pqw_pkg::WEIGHT_WIDTH-1:0]   rsp_weight_total,
   output logic [pqw_pkg::ERROR_WIDTH-1:0]           rsp_stack_error,
   output logic [pqw_pkg::FILL_WIDTH-1:0]            rsp_stack_fill
);

   localparam int TRIO_W  = 3 * COUNT_WIDTH;
   localparam int TAG_W   = $bits(pqw_pkg::tag_type);
   localparam int TOT_W   = pqw_pkg::TOTAL_WIDTH;
   localparam int WIDE_W  = (COUNT_WIDTH > TOT_W) ? COUNT_WIDTH : TOT_W;
   localparam int Z_W     = WIDE_W + 1;
   localparam int SUM_W   = WIDE_W + 2;
   localparam int A_W     = 2 * COUNT_WIDTH;
   localparam int B_W     = TOT_W + SUM_W;
   localparam int P_W     = A_W + B_W;
   localparam int W_W     = pqw_pkg::WEIGHT_WIDTH;
   localparam int IDX_W   = pqw_pkg::TERM_IDX_WIDTH;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_TERM = 3'b010,
      B_SUM  = 3'b100
   } bstate_type;

   bstate_type              bstate_ff, bstate_in;
   pqw_pkg::tag_type        head_tag, rec_tag_ff, out_tag;
   logic [TRIO_W-1:0]       rec_x_ff, rec_y_ff, rec_s_ff;
   logic [IDX_W-1:0]        issue_ff, issue_in, done_ff, done_in;
   logic                    issue_go, latch_rec, load_out, out_free;
   logic [5:0]              sides;
   logic [COUNT_WIDTH-1:0]  p_val, q_val, s_val;
   logic [TOT_W-1:0]        tot_val, r_val;
   logic [Z_W-1:0]          z_val;
   logic [SUM_W-1:0]        sum3;
   logic                    s1_valid_ff, s1_neg_ff, s1_zero_ff;
   logic [A_W-1:0]          a_ff;
   logic [B_W-1:0]          b_ff;
   logic [P_W-1:0]          prod;
   logic                    s2_valid_ff;
   logic signed [W_W-1:0]   term_ff, term_in, tsum_ff, tsum_in;
   logic signed [W_W-1:0]   weight_ff, weight_in, sat_sum, out_weight;
   logic [W_W:0]            sum_wide;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [W_W-1:0]   rsp_weight_ff;
   logic [pqw_pkg::ERROR_WIDTH-1:0] rsp_err_ff;
   logic [pqw_pkg::FILL_WIDTH-1:0]  rsp_fill_ff;

   assign head_tag = q_head[REC_WIDTH-1 -: TAG_W];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign issue_go = (bstate_ff == B_TERM) && (issue_ff != IDX_W'(pqw_pkg::TERM_COUNT));

   // Select the operands of the term being issued
   always_comb begin
      sides = pqw_pkg::term_sides(issue_ff);
      p_val = rec_x_ff[sides[5:4] * COUNT_WIDTH +: COUNT_WIDTH];
      q_val = rec_y_ff[sides[3:2] * COUNT_WIDTH +: COUNT_WIDTH];
      s_val = rec_s_ff[sides[1:0] * COUNT_WIDTH +: COUNT_WIDTH];
      unique case (sides[1:0])
         pqw_pkg::SIDE_A: tot_val = total_side_a;
         pqw_pkg::SIDE_B: tot_val = total_side_b;
         pqw_pkg::SIDE_C: tot_val = total_side_c;
         default:         tot_val = '0;
      endcase
      // complement count; when not negative it fits the total's width
      z_val = Z_W'(tot_val) - Z_W'(s_val);
      r_val = z_val[TOT_W-1:0];
      sum3  = SUM_W'(p_val) + SUM_W'(q_val) + SUM_W'(r_val) - SUM_W'(pqw_pkg::TERM_BIAS);
   end

   // Stage two product and term value
   always_comb begin
      prod = P_W'(a_ff) * P_W'(b_ff);
      if (s1_neg_ff) begin
         term_in = pqw_pkg::TERM_NEG_ONE;
      end else if (s1_zero_ff) begin
         term_in = '0;
      end else begin
         term_in = W_W'(prod);
      end
   end

   // Saturating weight update
   always_comb begin
      sum_wide = {weight_ff[W_W-1], weight_ff} + {tsum_ff[W_W-1], tsum_ff};
      if (sum_wide[W_W] != sum_wide[W_W-1]) begin
         sat_sum = sum_wide[W_W] ? pqw_pkg::WEIGHT_MIN : pqw_pkg::WEIGHT_MAX;
      end else begin
         sat_sum = sum_wide[W_W-1:0];
      end
   end

   // Sequencer
   always_comb begin
      bstate_in  = bstate_ff;
      q_pop      = 1'b0;
      latch_rec  = 1'b0;
      load_out   = 1'b0;
      out_tag    = head_tag;
      out_weight = weight_ff;
      weight_in  = weight_ff;
      unique case (bstate_ff)
         B_IDLE: begin
            if (!q_empty) begin
               if (head_tag.is_merge) begin
                  q_pop     = 1'b1;
                  latch_rec = 1'b1;
                  bstate_in = B_TERM;
               end else if (out_free) begin
                  q_pop    = 1'b1;
                  load_out = 1'b1;
               end
            end
         end
         B_TERM: begin
            if (done_ff == IDX_W'(pqw_pkg::TERM_COUNT)) begin
               bstate_in = B_SUM;
            end
         end
         B_SUM: begin
            if (out_free) begin
               load_out   = 1'b1;
               out_tag    = rec_tag_ff;
               out_weight = sat_sum;
               weight_in  = sat_sum;
               bstate_in  = B_IDLE;
            end
         end
         default: begin
            bstate_in = B_IDLE;
         end
      endcase
   end

   // Term counters and partial sum
   always_comb begin
      issue_in = issue_ff;
      done_in  = done_ff;
      tsum_in  = tsum_ff;
      if (latch_rec) begin
         issue_in = '0;
         done_in  = '0;
         tsum_in  = '0;
      end else begin
         if (issue_go) begin
            issue_in = issue_ff + IDX_W'(1);
         end
         if (s2_valid_ff) begin
            done_in = done_ff + IDX_W'(1);
            tsum_in = tsum_ff + term_ff;
         end
      end
   end

   // Drop the result once taken, load a new one when the slot frees
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff    <= B_IDLE;
         issue_ff     <= '0;
         done_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         weight_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bstate_ff    <= bstate_in;
         issue_ff     <= issue_in;
         done_ff      <= done_in;
         s1_valid_ff  <= issue_go;
         s2_valid_ff  <= s1_valid_ff;
         weight_ff    <= weight_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (latch_rec) begin
         rec_tag_ff <= head_tag;
         rec_x_ff   <= q_head[3 * TRIO_W - 1 -: TRIO_W];
         rec_y_ff   <= q_head[2 * TRIO_W - 1 -: TRIO_W];
         rec_s_ff   <= q_head[TRIO_W - 1 -: TRIO_W];
      end
      s1_neg_ff  <= z_val[Z_W-1];
      s1_zero_ff <= (p_val == '0) || (q_val == '0) || (r_val == '0);
      a_ff       <= A_W'(p_val) * A_W'(q_val);
      b_ff       <= B_W'(r_val) * B_W'(sum3);
      term_ff    <= term_in;
      tsum_ff    <= tsum_in;
      if (load_out) begin
         rsp_weight_ff <= out_weight;
         rsp_err_ff    <= out_tag.err;
         rsp_fill_ff   <= out_tag.fill;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_weight_total = rsp_weight_ff;
   assign rsp_stack_error  = rsp_err_ff;
   assign rsp_stack_fill   = rsp_fill_ff;

endmodule

// ===== rtl/postorder_quartet_weight_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postorder_quartet_weight_top
// Post-order tree token stream in, one stack status and running quartet
// weight out per token.
// ----------------------------------------------------------------------------
// Every token gives exactly one result, in token order. The front end pushes
// a leaf, end-of-tree or rejected token to the queue in the cycle it takes
// it; a good merge first reads the vector under the top from the stack
// memory into a register, then pushes the sum. Items wait in a four-entry
// queue for the back end, which passes a non-merge item to the result
// register; a merge it latches, issues its six F terms one a cycle through
// a shared two-stage multiplier, forms the partial sum, then does the
// saturating weight add. The back end's term unit sets the sustained rate:
// it takes no new item until a merge's weight is in the result register,
// which frees the back end as soon as the result is taken. The user is to
// write configuration registers (index 0 label map, 1 to 3 side totals)
// only while the block holds no item; the block does not enforce this.
// csr_ready is always high and writes to other indexes are dropped. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module postorder_quartet_weight_top #(
   parameter int STACK_DEPTH = pqw_pkg::DEF_STACK_DEPTH,
   parameter int LABEL_COUNT = pqw_pkg::DEF_LABEL_COUNT,
   parameter int COUNT_WIDTH = pqw_pkg::DEF_COUNT_WIDTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [pqw_pkg::OPCODE_WIDTH-1:0]         req_opcode,
   input  logic [pqw_pkg::LABEL_WIDTH-1:0]          req_leaf_label,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [pqw_pkg::WEIGHT_WIDTH-1:0]  rsp_weight_total,
   output logic [pqw_pkg::ERROR_WIDTH-1:0]          rsp_stack_error,
   output logic [pqw_pkg::FILL_WIDTH-1:0]           rsp_stack_fill,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [pqw_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [pqw_pkg::CSR_DATA_WIDTH-1:0]       csr_wdata
);

   localparam int REC_WIDTH = $bits(pqw_pkg::tag_type) + 9 * COUNT_WIDTH;
   localparam int TOT_W     = pqw_pkg::TOTAL_WIDTH;

   logic [pqw_pkg::MAP_WIDTH-1:0] side_map_ff;
   logic [TOT_W-1:0]              total_a_ff, total_b_ff, total_c_ff;
   logic                          q_push, q_full, q_pop, q_empty;
   logic [REC_WIDTH-1:0]          q_push_data, q_head;
   logic                          csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         side_map_ff <= '0;
         total_a_ff  <= '0;
         total_b_ff  <= '0;
         total_c_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            pqw_pkg::CSR_SIDE_MAP: side_map_ff <= csr_wdata;
            pqw_pkg::CSR_TOTAL_A:  total_a_ff  <= csr_wdata[TOT_W-1:0];
            pqw_pkg::CSR_TOTAL_B:  total_b_ff  <= csr_wdata[TOT_W-1:0];
            pqw_pkg::CSR_TOTAL_C:  total_c_ff  <= csr_wdata[TOT_W-1:0];
            default:               side_map_ff <= side_map_ff;
         endcase
      end
   end

   pqw_front #(
      .STACK_DEPTH (STACK_DEPTH),
      .LABEL_COUNT (LABEL_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_leaf_label (req_leaf_label),
      .side_map       (side_map_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_push_data)
   );

   pqw_queue #(
      .WIDTH (REC_WIDTH),
      .DEPTH (pqw_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_data (q_head)
   );

   pqw_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .total_side_a     (total_a_ff),
      .total_side_b     (total_b_ff),
      .total_side_c     (total_c_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_weight_total (rsp_weight_total),
      .rsp_stack_error  (rsp_stack_error),
      .rsp_stack_fill   (rsp_stack_fill)
   );

endmodule

// ===== rtl/pqw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqw_checker
// Port-level checks on the result channel of the quartet weight block,
// bound to the top level.
// ----------------------------------------------------------------------------
module pqw_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     rsp_valid,
   input logic                                     rsp_stall,
   input logic signed [pqw_pkg::WEIGHT_WIDTH-1:0]  rsp_weight_total,
   input logic [pqw_pkg::ERROR_WIDTH-1:0]          rsp_stack_error,
   input logic [pqw_pkg::FILL_WIDTH-1:0]           rsp_stack_fill
);

   // No result is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_weight_total)
         && $stable(rsp_stack_error) && $stable(rsp_stack_fill))
      else $error("stalled result changed");

   // Only defined status codes appear
   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_stack_error == pqw_pkg::ERR_NONE
         || rsp_stack_error == pqw_pkg::ERR_UNDERFLOW
         || rsp_stack_error == pqw_pkg::ERR_OVERFLOW))
      else $error("undefined stack status");

   // An underflowing merge leaves fewer than two vectors
   a_underflow_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stack_error == pqw_pkg::ERR_UNDERFLOW
         |-> rsp_stack_fill < pqw_pkg::FILL_WIDTH'(2))
      else $error("underflow reported with two or more vectors");

endmodule

bind postorder_quartet_weight_top pqw_checker u_pqw_checker (.*);

// ===== bench/postorder_quartet_weight_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postorder_quartet_weight_checker
// Watches the token, result and register channels of the quartet weight
// block. It keeps its own copy of the vector stack, the running weight and
// the register values, works out the result of every accepted token and
// checks each returned result against the oldest one still owed.
// ----------------------------------------------------------------------------
module postorder_quartet_weight_checker #(
   parameter int STACK_DEPTH = pqw_pkg::DEF_STACK_DEPTH,
   parameter int LABEL_COUNT = pqw_pkg::DEF_LABEL_COUNT,
   parameter int COUNT_WIDTH = pqw_pkg::DEF_COUNT_WIDTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_stall,
   input  logic [pqw_pkg::OPCODE_WIDTH-1:0]         req_opcode,
   input  logic [pqw_pkg::LABEL_WIDTH-1:0]          req_leaf_label,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   input  logic signed [pqw_pkg::WEIGHT_WIDTH-1:0]  rsp_weight_total,
   input  logic [pqw_pkg::ERROR_WIDTH-1:0]          rsp_stack_error,
   input  logic [pqw_pkg::FILL_WIDTH-1:0]           rsp_stack_fill,
   input  logic                                     csr_valid,
   input  logic                                     csr_ready,
   input  logic [pqw_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [pqw_pkg::CSR_DATA_WIDTH-1:0]       csr_wdata,
   output int                                       fail_count,
   output int                                       pending_count
);
   import pqw_pkg::*;

   // Three side counts, indexed by side code
   typedef logic [2:0][COUNT_WIDTH-1:0] trio_type;

   typedef struct packed {
      logic signed [WEIGHT_WIDTH-1:0] weight;
      error_type                      err;
      logic [FILL_WIDTH-1:0]          fill;
   } outcome_type;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   trio_type                       side_stack [STACK_DEPTH];
   int unsigned                    stack_depth;
   logic signed [WEIGHT_WIDTH-1:0] weight_acc;
   logic [MAP_WIDTH-1:0]           label_map;
   logic [TOTAL_WIDTH-1:0]         side_total [3];
   outcome_type                    outcome_q [$];
   outcome_type                    predicted;
   outcome_type                    oldest;
   int                             failures = 0;

   // One quartet term; any negative count makes it minus one
   function automatic longint quartet_term(input longint p, input longint q,
                                           input longint r);
      if (p < 0 || q < 0 || r < 0)
         return TERM_NEG_ONE;
      return (p + q + r - TERM_BIAS) * p * q * r;
   endfunction

   // Add with clamping at the signed 64-bit limits
   function automatic logic signed [WEIGHT_WIDTH-1:0] weight_add(
      input logic signed [WEIGHT_WIDTH-1:0] acc, input longint delta);
      logic signed [WEIGHT_WIDTH:0] wide;
      wide = (WEIGHT_WIDTH+1)'(acc);
      wide = wide + (WEIGHT_WIDTH+1)'(delta);
      if (wide > (WEIGHT_WIDTH+1)'(WEIGHT_MAX))
         return WEIGHT_MAX;
      if (wide < (WEIGHT_WIDTH+1)'(WEIGHT_MIN))
         return WEIGHT_MIN;
      return wide[WEIGHT_WIDTH-1:0];
   endfunction

   // Apply one token to the stack and weight, give the result it owes
   task automatic apply_token(input logic [OPCODE_WIDTH-1:0] op,
                              input logic [LABEL_WIDTH-1:0] label,
                              output outcome_type res);
      trio_type                 top_v;
      trio_type                 under_v;
      trio_type                 sum_v;
      trio_type                 leaf_v;
      logic [COUNT_WIDTH:0]     wide_cnt;
      logic [1:0]               code;
      longint                   comp [3];
      longint                   xs [3];
      longint                   ys [3];
      longint                   delta;
      int                       k;
      res.err = ERR_NONE;
      case (op)
         OP_LEAF: begin
            if (stack_depth >= STACK_DEPTH) begin
               res.err = ERR_OVERFLOW;
            end else begin
               leaf_v = '0;
               code = SIDE_NONE;
               if (int'(label) < LABEL_COUNT)
                  code = label_map[2*int'(label) +: 2];
               if (code != SIDE_NONE)
                  leaf_v[code] = COUNT_WIDTH'(1);
               side_stack[stack_depth] = leaf_v;
               stack_depth++;
            end
         end
         OP_MERGE: begin
            if (stack_depth < 2) begin
               res.err = ERR_UNDERFLOW;
            end else begin
               top_v   = side_stack[stack_depth-1];
               under_v = side_stack[stack_depth-2];
               // Sum the two subtrees, clamping each count
               for (k = 0; k < 3; k++) begin
                  wide_cnt = {1'b0, top_v[k]} + {1'b0, under_v[k]};
                  sum_v[k] = wide_cnt[COUNT_WIDTH] ? COUNT_MAX
                                                   : wide_cnt[COUNT_WIDTH-1:0];
                  comp[k]  = longint'(side_total[k]) - longint'(sum_v[k]);
                  xs[k]    = longint'(top_v[k]);
                  ys[k]    = longint'(under_v[k]);
               end
               stack_depth--;
               side_stack[stack_depth-1] = sum_v;
               delta = quartet_term(xs[SIDE_A], ys[SIDE_B], comp[SIDE_C])
                     + quartet_term(xs[SIDE_A], ys[SIDE_C], comp[SIDE_B])
                     + quartet_term(xs[SIDE_B], ys[SIDE_A], comp[SIDE_C])
                     + quartet_term(xs[SIDE_B], ys[SIDE_C], comp[SIDE_A])
                     + quartet_term(xs[SIDE_C], ys[SIDE_A], comp[SIDE_B])
                     + quartet_term(xs[SIDE_C], ys[SIDE_B], comp[SIDE_A]);
               weight_acc = weight_add(weight_acc, delta);
            end
         end
         OP_END: begin
            stack_depth = 0;
         end
         default: ;
      endcase
      res.weight = weight_acc;
      res.fill   = FILL_WIDTH'(stack_depth);
   endtask

   // Count a failure and report it
   task automatic flag_mismatch(input string field,
                                input logic signed [WEIGHT_WIDTH-1:0] want,
                                input logic signed [WEIGHT_WIDTH-1:0] got);
      failures++;
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stack_depth = 0;
         weight_acc  = '0;
         label_map   = '0;
         side_total  = '{default: '0};
         outcome_q.delete();
      end else begin
         // Check a returned result against the oldest one owed
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               failures++;
               $display("%0t: result with no token waiting, expected none got weight %0d",
                        $time, rsp_weight_total);
            end else begin
               oldest = outcome_q.pop_front();
               if (rsp_weight_total !== oldest.weight)
                  flag_mismatch("weight_total", oldest.weight, rsp_weight_total);
               if (rsp_stack_error !== oldest.err)
                  flag_mismatch("stack_error", WEIGHT_WIDTH'(oldest.err),
                                WEIGHT_WIDTH'(rsp_stack_error));
               if (rsp_stack_fill !== oldest.fill)
                  flag_mismatch("stack_fill", WEIGHT_WIDTH'(oldest.fill),
                                WEIGHT_WIDTH'(rsp_stack_fill));
            end
         end
         // Track register writes; other indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SIDE_MAP: label_map = csr_wdata;
               CSR_TOTAL_A:  side_total[SIDE_A] = csr_wdata[TOTAL_WIDTH-1:0];
               CSR_TOTAL_B:  side_total[SIDE_B] = csr_wdata[TOTAL_WIDTH-1:0];
               CSR_TOTAL_C:  side_total[SIDE_C] = csr_wdata[TOTAL_WIDTH-1:0];
               default: ;
            endcase
         end
         // Work out the result of an accepted token
         if (req_valid && !req_stall) begin
            apply_token(req_opcode, req_leaf_label, predicted);
            outcome_q.push_back(predicted);
         end
      end
      pending_count <= outcome_q.size();
      fail_count    <= failures;
   end

endmodule

// ===== bench/postorder_quartet_weight_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postorder_quartet_weight_top_tb
// Drives post-order token streams into the quartet weight block: a short
// directed run over the stack errors and side cases, then phases of random
// trees, long chains, noise and broken sequences under changing register
// settings, with random gaps and result stalls. The checker does the
// predicting and comparing; this module gives the verdict.
// ----------------------------------------------------------------------------
module postorder_quartet_weight_top_tb;
   import pqw_pkg::*;

   localparam int CLOCK_HALF   = 10;
   localparam int RESET_CYCLES = 10;
   localparam int RANDOM_ITEMS = 1950;
   localparam int PHASE_ITEMS  = 220;
   localparam int IDLE_PERCENT = 15;
   localparam int DRAIN_CYCLES = 30;
   localparam int CYCLE_LIMIT  = 500000;

   // Opcode with no meaning to the block, and an index with no register
   localparam logic [OPCODE_WIDTH-1:0]    OP_SPARE   = 2'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 3'd6;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [OPCODE_WIDTH-1:0]           req_opcode = OP_END;
   logic [LABEL_WIDTH-1:0]            req_leaf_label = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [WEIGHT_WIDTH-1:0]    rsp_weight_total;
   logic [ERROR_WIDTH-1:0]            rsp_stack_error;
   logic [FILL_WIDTH-1:0]             rsp_stack_fill;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]        csr_index = CSR_SIDE_MAP;
   logic [CSR_DATA_WIDTH-1:0]         csr_wdata = '0;

   int  fail_count;
   int  pending_count;
   int  cycle_count = 0;
   int  sent_items = 0;
   bit  idle_enable = 1'b1;

   postorder_quartet_weight_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_leaf_label   (req_leaf_label),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_weight_total (rsp_weight_total),
      .rsp_stack_error  (rsp_stack_error),
      .rsp_stack_fill   (rsp_stack_fill),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   postorder_quartet_weight_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_leaf_label   (req_leaf_label),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_weight_total (rsp_weight_total),
      .rsp_stack_error  (rsp_stack_error),
      .rsp_stack_fill   (rsp_stack_fill),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always #CLOCK_HALF clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("postorder_quartet_weight_top verification failed");
         $finish;
      end
   end

   // Stall the result side at random while idling is on
   always @(posedge clock) begin
      if (idle_enable)
         rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
      else
         rsp_stall <= 1'b0;
   end

   // Random label and random token kind at field width
   function automatic logic [LABEL_WIDTH-1:0] rand_label();
      return LABEL_WIDTH'($urandom_range(31));
   endfunction

   function automatic logic [OPCODE_WIDTH-1:0] rand_opcode();
      return OPCODE_WIDTH'($urandom_range(3));
   endfunction

   // Offer one token, maybe after a gap, and hold it until taken
   task automatic send_token(input logic [OPCODE_WIDTH-1:0] op,
                             input logic [LABEL_WIDTH-1:0] label);
      if (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_leaf_label <= label;
      do @(posedge clock); while (req_stall);
      if (op != OP_SPARE)
         sent_items++;
   endtask

   // Write one register; the caller drops valid after the last write
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_config(input logic [CSR_DATA_WIDTH-1:0] map,
                             input logic [CSR_DATA_WIDTH-1:0] total_a,
                             input logic [CSR_DATA_WIDTH-1:0] total_b,
                             input logic [CSR_DATA_WIDTH-1:0] total_c);
      write_reg(CSR_SIDE_MAP, map);
      write_reg(CSR_TOTAL_A, total_a);
      write_reg(CSR_TOTAL_B, total_b);
      write_reg(CSR_TOTAL_C, total_c);
      csr_valid <= 1'b0;
   endtask

   // Wait until every result owed has been taken
   task automatic wait_drained();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Mostly small totals so complements stay positive, sometimes wide data
   function automatic logic [CSR_DATA_WIDTH-1:0] pick_total();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50)
         return CSR_DATA_WIDTH'($urandom_range(40));
      if (roll < 75)
         return CSR_DATA_WIDTH'($urandom_range(255));
      return {$urandom, $urandom};
   endfunction

   // Random well-formed post-order tree
   task automatic send_tree(input int leaves, input bit close);
      int left;
      int depth;
      left  = leaves;
      depth = 0;
      while (left > 0 || depth > 1) begin
         if (left > 0 && (depth < 2 || $urandom_range(1) == 1)) begin
            send_token(OP_LEAF, rand_label());
            left--;
            depth++;
         end else begin
            send_token(OP_MERGE, rand_label());
            depth--;
         end
      end
      if (close)
         send_token(OP_END, rand_label());
   endtask

   // Caterpillar: grow one subtree a leaf at a time
   task automatic send_chain(input int links);
      send_token(OP_LEAF, rand_label());
      repeat (links) begin
         send_token(OP_LEAF, rand_label());
         send_token(OP_MERGE, rand_label());
      end
      if ($urandom_range(3) != 0)
         send_token(OP_END, rand_label());
   endtask

   task automatic send_sequence();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         send_tree($urandom_range(1, 32), $urandom_range(9) != 0);
      end else if (pick < 70) begin
         send_chain($urandom_range(2, 40));
      end else if (pick < 85) begin
         repeat ($urandom_range(1, 6)) send_token(rand_opcode(), rand_label());
      end else if ($urandom_range(1) == 0) begin
         // Merges on an empty and a one-deep stack
         send_token(OP_END, rand_label());
         send_token(OP_MERGE, rand_label());
         send_token(OP_LEAF, rand_label());
         send_token(OP_MERGE, rand_label());
         send_token(OP_MERGE, rand_label());
      end else begin
         // Push past a full stack
         send_token(OP_END, rand_label());
         repeat ($urandom_range(33, 36)) send_token(OP_LEAF, rand_label());
         send_token(OP_MERGE, rand_label());
         send_token(OP_END, rand_label());
      end
   endtask

   initial begin
      int phase;
      int phase_start;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: labels cycle a, b, c, none; side a total zero
      set_config(64'hE4E4_E4E4_E4E4_E4E4, 64'd0, 64'd255, 64'd2);
      send_token(OP_MERGE, 5'd0);
      send_token(OP_LEAF, 5'd0);
      send_token(OP_MERGE, 5'd31);
      send_token(OP_SPARE, 5'd31);
      send_token(OP_LEAF, 5'd5);
      send_token(OP_MERGE, 5'd0);
      send_token(OP_LEAF, 5'd10);
      send_token(OP_LEAF, 5'd31);
      send_token(OP_MERGE, 5'd0);
      send_token(OP_MERGE, 5'd0);
      send_token(OP_LEAF, 5'd12);
      send_token(OP_LEAF, 5'd17);
      send_token(OP_LEAF, 5'd30);
      send_token(OP_MERGE, 5'd0);
      send_token(OP_MERGE, 5'd0);
      send_token(OP_MERGE, 5'd0);
      send_token(OP_END, 5'd21);
      send_token(OP_MERGE, 5'd0);
      send_token(OP_LEAF, 5'd3);
      send_token(OP_END, 5'd0);
      req_valid <= 1'b0;

      // Random phases, each under its own register setting
      sent_items = 0;
      phase = 0;
      while (sent_items < RANDOM_ITEMS) begin
         wait_drained();
         idle_enable = (phase != 2);
         case (phase)
            0: set_config(64'h9000_0000_0000_0000, '1, '1, '1);
            1: begin
               write_reg(CSR_UNUSED, {$urandom, $urandom});
               set_config('1, 64'd0, 64'd0, 64'd0);
            end
            2: set_config('0, pick_total(), pick_total(), pick_total());
            default: set_config({$urandom, $urandom}, pick_total(), pick_total(),
                                pick_total());
         endcase
         // Long chain first: drive side a counts into clamping
         if (phase == 0) begin
            send_chain(320);
            send_token(OP_END, rand_label());
         end
         phase_start = sent_items;
         while (sent_items - phase_start < PHASE_ITEMS && sent_items < RANDOM_ITEMS)
            send_sequence();
         req_valid <= 1'b0;
         phase++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("postorder_quartet_weight_top verification clean");
      else
         $display("postorder_quartet_weight_top verification failed");
      $finish;
   end

endmodule
